// ===== rtl/scpg_pkg.sv =====
// ----------------------------------------------------------------------------
// scpg_pkg - shared types and constants of the pointing gate
// Register indexes, reset values, sequencer steps and the state encoding.
// ----------------------------------------------------------------------------
package scpg_pkg;

    // Configuration register indexes and data width.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_REACH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REACH_CEILING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FRACTION = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_FRACTION = 2'd3;

    localparam logic [11:0] RST_INITIAL_REACH  = 12'd287;
    localparam logic [11:0] RST_REACH_CEILING  = 12'd532;
    localparam logic [7:0]  RST_START_FRACTION = 8'd192;
    localparam logic [7:0]  RST_STOP_FRACTION  = 8'd141;

    // Squared reach is 24 bits; the squared distance saturates at 2^24.
    localparam int REACH_W = 24;
    localparam int DC_W    = REACH_W + 1;
    localparam logic [DC_W-1:0] D2_CAP = 25'h100_0000;

    // Sequencer steps. The multiplier result of one step is consumed
    // in the next one.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STP_IR      = 4'd0;
    localparam logic [STEP_W-1:0] STP_RC      = 4'd1;
    localparam logic [STEP_W-1:0] STP_SF      = 4'd2;
    localparam logic [STEP_W-1:0] STP_STF     = 4'd3;
    localparam logic [STEP_W-1:0] STP_DX      = 4'd4;
    localparam logic [STEP_W-1:0] STP_DY      = 4'd5;
    localparam logic [STEP_W-1:0] STP_DZ      = 4'd6;
    localparam logic [STEP_W-1:0] STP_SUM     = 4'd7;
    localparam logic [STEP_W-1:0] STP_REACH   = 4'd8;
    localparam logic [STEP_W-1:0] STP_THR_ON  = 4'd9;
    localparam logic [STEP_W-1:0] STP_THR_OFF = 4'd10;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

// ===== rtl/scpg_in_if.sv =====
// ----------------------------------------------------------------------------
// scpg_in_if - pose sample channel
// Valid/ready channel carrying one hand's fingertip and palm positions.
// ----------------------------------------------------------------------------
interface scpg_in_if #(
    parameter int POS_BITS = 20
);
    logic                       valid;
    logic                       ready;
    logic                       hand;
    logic                       tracked;
    logic signed [POS_BITS-1:0] tip_x;
    logic signed [POS_BITS-1:0] tip_y;
    logic signed [POS_BITS-1:0] tip_z;
    logic signed [POS_BITS-1:0] palm_x;
    logic signed [POS_BITS-1:0] palm_y;
    logic signed [POS_BITS-1:0] palm_z;

    modport source (
        output valid, hand, tracked, tip_x, tip_y, tip_z, palm_x, palm_y, palm_z,
        input  ready
    );
    modport sink (
        input  valid, hand, tracked, tip_x, tip_y, tip_z, palm_x, palm_y, palm_z,
        output ready
    );
endinterface

// ===== rtl/scpg_out_if.sv =====
// ----------------------------------------------------------------------------
// scpg_out_if - gate result channel
// Valid/ready channel carrying the gate state and pulses of one sample.
// ----------------------------------------------------------------------------
interface scpg_out_if;
    logic valid;
    logic ready;
    logic hand_out;
    logic pointing;
    logic start_pulse;
    logic stop_pulse;
    logic move_request;

    modport source (
        output valid, hand_out, pointing, start_pulse, stop_pulse, move_request,
        input  ready
    );
    modport sink (
        input  valid, hand_out, pointing, start_pulse, stop_pulse, move_request,
        output ready
    );
endinterface

// ===== rtl/scpg_mul.sv =====
// ----------------------------------------------------------------------------
// scpg_mul - shared unsigned multiplier
// One multiply per cycle when enabled, product held in a register.
// ----------------------------------------------------------------------------
module scpg_mul #(
    parameter int MW = 24
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [MW-1:0]   i_a,
    input  logic [MW-1:0]   i_b,
    output logic [2*MW-1:0] o_prod
);
    logic [2*MW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;
endmodule

// ===== rtl/self_calibrating_pointing_gate.sv =====
// ----------------------------------------------------------------------------
// self_calibrating_pointing_gate - per-hand pointing detector
// Squared fingertip-to-palm distance against a self-calibrating squared reach,
// with start and stop thresholds that give the gate hysteresis.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Payload                                         | Word
//  ---------+-----+-------------------------------------------------+---------
//  i_in     | in  | hand, tracked, tip_x/y/z, palm_x/y/z            | sample
//  o_out    | out | hand_out, pointing, start/stop_pulse, move_req  | result
//  i_cfg_*  | in  | we, idx, wdata (write only)                     | register
//
// A tracked word runs from its acceptance through eleven sequencer steps on the
// single shared multiplier and the decision state, then returns to the idle
// state in which the next word is taken. An untracked word goes from idle
// straight to the decision state and back to idle.
// Reset is synchronous and active low; it clears both hands' reach and gate.
// A result that is not taken holds the sequencer in its decision cycle; the
// input stays ready while the previous result still waits in o_out.
//
module self_calibrating_pointing_gate #(
    parameter int POS_BITS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    scpg_in_if.sink                       i_in,
    scpg_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [scpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [scpg_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import scpg_pkg::*;

    // Absolute coordinate differences fit in POS_BITS+1 bits. The shared
    // multiplier must also take a 24-bit squared reach.
    localparam int DW = POS_BITS + 1;
    localparam int MW = (DW > REACH_W) ? DW : REACH_W;
    localparam int PW = 2 * MW;

    // Configuration registers.
    logic [11:0] r_initial_reach;
    logic [11:0] r_reach_ceiling;
    logic [7:0]  r_start_fraction;
    logic [7:0]  r_stop_fraction;

    // Per-hand state.
    logic [REACH_W-1:0] r_reach_sq [2];
    logic [1:0]         r_gate;

    // Sequencer and working registers.
    t_state             r_state;
    logic [STEP_W-1:0]  r_step;
    logic               r_hand;
    logic               r_trk;
    logic [DW-1:0]      r_dx;
    logic [DW-1:0]      r_dy;
    logic [DW-1:0]      r_dz;
    logic [REACH_W-1:0] r_floor_sq;
    logic [REACH_W-1:0] r_ceil_sq;
    logic [15:0]        r_sf2;
    logic [15:0]        r_stf2;
    logic [DC_W-1:0]    r_dc;
    logic [REACH_W-1:0] r_reach;
    logic               r_start_hit;

    // Output register.
    logic r_out_valid;
    logic r_out_hand;
    logic r_out_pointing;
    logic r_out_start;
    logic r_out_stop;
    logic r_out_move;

    // Multiplier interface.
    logic          mul_en;
    logic [MW-1:0] mul_a;
    logic [MW-1:0] mul_b;
    logic [PW-1:0] mul_prod;

    // Absolute difference of two signed positions.
    function automatic logic [DW-1:0] abs_diff(input logic [POS_BITS-1:0] a,
                                               input logic [POS_BITS-1:0] b);
        logic signed [DW-1:0] d;
        d = $signed({a[POS_BITS-1], a}) - $signed({b[POS_BITS-1], b});
        return d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    scpg_mul #(.MW(MW)) u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // Operand selection for each step of the sequence.
    always_comb begin
        mul_en = (r_state == S_MUL);
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_step)
            STP_IR: begin
                mul_a = MW'(r_initial_reach);
                mul_b = MW'(r_initial_reach);
            end
            STP_RC: begin
                mul_a = MW'(r_reach_ceiling);
                mul_b = MW'(r_reach_ceiling);
            end
            STP_SF: begin
                mul_a = MW'(r_start_fraction);
                mul_b = MW'(r_start_fraction);
            end
            STP_STF: begin
                mul_a = MW'(r_stop_fraction);
                mul_b = MW'(r_stop_fraction);
            end
            STP_DX: begin
                mul_a = MW'(r_dx);
                mul_b = MW'(r_dx);
            end
            STP_DY: begin
                mul_a = MW'(r_dy);
                mul_b = MW'(r_dy);
            end
            STP_DZ: begin
                mul_a = MW'(r_dz);
                mul_b = MW'(r_dz);
            end
            STP_THR_ON: begin
                mul_a = MW'(r_sf2);
                mul_b = MW'(r_reach);
            end
            STP_THR_OFF: begin
                mul_a = MW'(r_stf2);
                mul_b = MW'(r_reach);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Saturating accumulation of the squared distance.
    logic [PW:0]     acc_sum;
    logic [DC_W-1:0] acc_sat;
    assign acc_sum = (PW + 1)'(r_dc) + (PW + 1)'(mul_prod);
    assign acc_sat = (acc_sum > (PW + 1)'(D2_CAP)) ? D2_CAP : acc_sum[DC_W-1:0];

    // Reach update: raise to the floor, then to the distance, then clamp.
    logic [DC_W-1:0] reach_a;
    logic [DC_W-1:0] reach_b;
    logic [DC_W-1:0] reach_c;
    always_comb begin
        reach_a = DC_W'(r_reach_sq[r_hand]);
        if (reach_a < DC_W'(r_floor_sq)) begin
            reach_a = DC_W'(r_floor_sq);
        end
        reach_b = (r_dc > reach_a) ? r_dc : reach_a;
        reach_c = (reach_b > DC_W'(r_ceil_sq)) ? DC_W'(r_ceil_sq) : reach_b;
    end

    // Distance scaled by 2^16 against fraction^2 times reach.
    logic [PW-1:0] lhs;
    assign lhs = PW'({r_dc, 16'b0});

    logic out_free;
    logic was_on;
    logic stop_hit;
    assign out_free = !r_out_valid || o_out.ready;
    assign was_on   = r_gate[r_hand];
    assign stop_hit = lhs < mul_prod;

    assign i_in.ready = (r_state == S_IDLE);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_reach  <= RST_INITIAL_REACH;
            r_reach_ceiling  <= RST_REACH_CEILING;
            r_start_fraction <= RST_START_FRACTION;
            r_stop_fraction  <= RST_STOP_FRACTION;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INITIAL_REACH:  r_initial_reach  <= i_cfg_wdata;
                CFG_REACH_CEILING:  r_reach_ceiling  <= i_cfg_wdata;
                CFG_START_FRACTION: r_start_fraction <= i_cfg_wdata[7:0];
                CFG_STOP_FRACTION:  r_stop_fraction  <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Sequencer, per-hand state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_step        <= STP_IR;
            r_gate        <= '0;
            r_reach_sq[0] <= '0;
            r_reach_sq[1] <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // A new result takes priority over draining the old one.
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_step  <= STP_IR;
                        r_state <= i_in.tracked ? S_MUL : S_DONE;
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STP_THR_OFF) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state     <= S_IDLE;
                        if (r_trk) begin
                            r_reach_sq[r_hand] <= r_reach;
                            if (!was_on && r_start_hit) begin
                                r_gate[r_hand] <= 1'b1;
                            end else if (was_on && stop_hit) begin
                                r_gate[r_hand] <= 1'b0;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Working data path; no reset needed.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_hand <= i_in.hand;
            r_trk  <= i_in.tracked;
            r_dx   <= abs_diff(i_in.tip_x, i_in.palm_x);
            r_dy   <= abs_diff(i_in.tip_y, i_in.palm_y);
            r_dz   <= abs_diff(i_in.tip_z, i_in.palm_z);
            r_dc   <= '0;
        end
        if (r_state == S_MUL) begin
            case (r_step)
                STP_RC:      r_floor_sq  <= mul_prod[REACH_W-1:0];
                STP_SF:      r_ceil_sq   <= mul_prod[REACH_W-1:0];
                STP_STF:     r_sf2       <= mul_prod[15:0];
                STP_DX:      r_stf2      <= mul_prod[15:0];
                STP_DY,
                STP_DZ,
                STP_SUM:     r_dc        <= acc_sat;
                STP_REACH:   r_reach     <= reach_c[REACH_W-1:0];
                STP_THR_OFF: r_start_hit <= lhs > mul_prod;
                default: ;
            endcase
        end
        if (r_state == S_DONE && out_free) begin
            r_out_hand <= r_hand;
            if (r_trk && !was_on && r_start_hit) begin
                r_out_pointing <= 1'b1;
                r_out_start    <= 1'b1;
                r_out_stop     <= 1'b0;
                r_out_move     <= 1'b1;
            end else if (r_trk && was_on && stop_hit) begin
                r_out_pointing <= 1'b0;
                r_out_start    <= 1'b0;
                r_out_stop     <= 1'b1;
                r_out_move     <= 1'b0;
            end else begin
                r_out_pointing <= was_on;
                r_out_start    <= 1'b0;
                r_out_stop     <= 1'b0;
                r_out_move     <= r_trk && was_on;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.hand_out     = r_out_hand;
    assign o_out.pointing     = r_out_pointing;
    assign o_out.start_pulse  = r_out_start;
    assign o_out.stop_pulse   = r_out_stop;
    assign o_out.move_request = r_out_move;

    // The step counter never runs past the last threshold step.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_step <= STP_THR_OFF))
        else $error("sequencer step out of range");

    // A result never reports both an edge on and an edge off.
    a_one_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.start_pulse && o_out.stop_pulse))
        else $error("start and stop pulse together");

    // A move request is only issued while the gate is on.
    a_move_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.move_request || o_out.pointing))
        else $error("move request without pointing");

    // Finishing a word always presents a result in the next cycle.
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_out.valid && r_state == S_IDLE))
        else $error("finished word did not reach the output");

endmodule

// ===== tb/sv/self_calibrating_pointing_gate_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// self_calibrating_pointing_gate_tb - self-checking bench for the pointing gate
// Drives pose sample words through the input channel and registers through the
// write port. Each accepted word is run through a bench-side model of the
// per-hand reach and gate. The model's result is queued and compared, field by
// field, with every result word taken from the output channel. Both sides idle
// at random, and once the receiver holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module self_calibrating_pointing_gate_tb;

    import scpg_pkg::*;

    localparam int POS_BITS = 20;
    localparam int POS_MAX_I = (1 << (POS_BITS - 1)) - 1;
    localparam int POS_MIN_I = -(1 << (POS_BITS - 1));

    typedef longint unsigned u64_t;

    // The squared distance is saturated at 2^24 before any comparison.
    localparam u64_t DIST_SQ_CAP = u64_t'(1) << 24;

    // Extra wait after the last result is back; it covers a tracked word with margin
    // when the bench lets the block settle before a register write or the end.
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic                       hand;
        logic                       tracked;
        logic signed [POS_BITS-1:0] tip_x, tip_y, tip_z;
        logic signed [POS_BITS-1:0] palm_x, palm_y, palm_z;
    } pose_t;

    typedef struct {
        logic hand_out;
        logic pointing;
        logic start_pulse;
        logic stop_pulse;
        logic move_request;
    } gate_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    scpg_in_if #(.POS_BITS(POS_BITS)) pose_if ();
    scpg_out_if                       gate_if ();

    self_calibrating_pointing_gate #(
        .POS_BITS(POS_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (pose_if),
        .o_out      (gate_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Bench copy of the registers and of the per-hand state.
    logic [11:0] cfg_initial_reach = RST_INITIAL_REACH;
    logic [11:0] cfg_reach_ceiling = RST_REACH_CEILING;
    logic [7:0]  cfg_start_frac    = RST_START_FRACTION;
    logic [7:0]  cfg_stop_frac     = RST_STOP_FRACTION;
    logic [23:0] reach_sq_by_hand [2] = '{24'd0, 24'd0};
    logic        gate_on_by_hand  [2] = '{1'b0, 1'b0};

    // Predicted result words, oldest first.
    gate_result_t gate_results_due [$];
    int           fail_count = 0;

    // Idle rates in percent per cycle, and a pending receiver hold-off.
    int src_idle_pct  = 16;
    int sink_idle_pct = 16;
    int hold_off_req  = 0;

    // ------------------------------------------------------------------------
    // Clock and run limit.
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The slowest correct run is roughly 100 us; this is many times that.
    initial begin
        #2_000_000;
        $display("** self_calibrating_pointing_gate: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model of the gate. Called once per accepted sample word, in order, so
    // the per-hand state advances exactly as the block's does.
    // ------------------------------------------------------------------------
    function automatic u64_t axis_sq(input logic signed [POS_BITS-1:0] a,
                                     input logic signed [POS_BITS-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return u64_t'(d) * u64_t'(d);
    endfunction

    function automatic gate_result_t predict_gate(input pose_t p);
        gate_result_t res;
        u64_t d2, dc, floor_sq, ceil_sq, reach, lhs, on_thr, off_thr;
        logic was_on;
        was_on = gate_on_by_hand[p.hand];
        res = '{default: 1'b0};
        res.hand_out = p.hand;
        // An untracked word leaves the state alone and carries no pulses.
        if (p.tracked) begin
            d2 = axis_sq(p.tip_x, p.palm_x) + axis_sq(p.tip_y, p.palm_y)
                 + axis_sq(p.tip_z, p.palm_z);
            dc = (d2 > DIST_SQ_CAP) ? DIST_SQ_CAP : d2;
            floor_sq = u64_t'(cfg_initial_reach) * u64_t'(cfg_initial_reach);
            ceil_sq  = u64_t'(cfg_reach_ceiling) * u64_t'(cfg_reach_ceiling);
            // Floor first, then grow, then clamp: the clamp wins when the
            // ceiling lies below the floor.
            reach = u64_t'(reach_sq_by_hand[p.hand]);
            if (reach < floor_sq)
                reach = floor_sq;
            if (dc > reach)
                reach = dc;
            if (reach > ceil_sq)
                reach = ceil_sq;
            reach_sq_by_hand[p.hand] = reach[23:0];
            // Thresholds compared in the squared domain, fractions over 256.
            lhs     = dc << 16;
            on_thr  = u64_t'(cfg_start_frac) * u64_t'(cfg_start_frac) * reach;
            off_thr = u64_t'(cfg_stop_frac) * u64_t'(cfg_stop_frac) * reach;
            if (!was_on && lhs > on_thr) begin
                gate_on_by_hand[p.hand] = 1'b1;
                res.start_pulse = 1'b1;
            end else if (was_on && lhs < off_thr) begin
                gate_on_by_hand[p.hand] = 1'b0;
                res.stop_pulse = 1'b1;
            end
            res.move_request = gate_on_by_hand[p.hand];
        end
        res.pointing = gate_on_by_hand[p.hand];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver. Ready changes at the falling edge only. A hold-off request
    // is picked up here and counted down in cycles; meanwhile ready stays low.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        int hold_left;
        if (hold_off_req > 0) begin
            hold_left = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            gate_if.ready <= 1'b0;
        end else begin
            gate_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker. Values are sampled at the rising edge, before the block
    // updates anything at that edge.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        gate_result_t want;
        if (i_rst_n && gate_if.valid && gate_if.ready) begin
            if (gate_results_due.size() == 0) begin
                $error("result word with no sample waiting for it");
                fail_count++;
            end else begin
                want = gate_results_due.pop_front();
                check_field("hand_out", want.hand_out, gate_if.hand_out);
                check_field("pointing", want.pointing, gate_if.pointing);
                check_field("start_pulse", want.start_pulse, gate_if.start_pulse);
                check_field("stop_pulse", want.stop_pulse, gate_if.stop_pulse);
                check_field("move_request", want.move_request, gate_if.move_request);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Offers one sample word, holding valid high until it is taken,
    // and queues the model's result at the edge of acceptance. Random idle
    // cycles go in front of the word, so gaps land on every sequencer step.
    // ------------------------------------------------------------------------
    task automatic send_pose(input pose_t p);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            pose_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        pose_if.valid   <= 1'b1;
        pose_if.hand    <= p.hand;
        pose_if.tracked <= p.tracked;
        pose_if.tip_x   <= p.tip_x;
        pose_if.tip_y   <= p.tip_y;
        pose_if.tip_z   <= p.tip_z;
        pose_if.palm_x  <= p.palm_x;
        pose_if.palm_y  <= p.palm_y;
        pose_if.palm_z  <= p.palm_z;
        do
            @(posedge i_clk);
        while (!pose_if.ready);
        gate_results_due.push_back(predict_gate(p));
    endtask

    // Drops valid and waits until every predicted result has come back, then
    // waits out the settle margin as well, so the block is truly idle.
    task automatic settle_block();
        @(negedge i_clk);
        pose_if.valid <= 1'b0;
        while (gate_results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_INITIAL_REACH:  cfg_initial_reach = value[11:0];
            CFG_REACH_CEILING:  cfg_reach_ceiling = value[11:0];
            CFG_START_FRACTION: cfg_start_frac = value[7:0];
            CFG_STOP_FRACTION:  cfg_stop_frac = value[7:0];
            default: ;
        endcase
    endtask

    // Registers are only written with the block idle.
    task automatic write_all_cfg(input int unsigned reach_floor, input int unsigned reach_cap,
                                 input int unsigned start_frac, input int unsigned stop_frac);
        settle_block();
        write_cfg(CFG_INITIAL_REACH, reach_floor);
        write_cfg(CFG_REACH_CEILING, reach_cap);
        write_cfg(CFG_START_FRACTION, start_frac);
        write_cfg(CFG_STOP_FRACTION, stop_frac);
    endtask

    // ------------------------------------------------------------------------
    // Sample builders.
    // ------------------------------------------------------------------------
    function automatic pose_t make_pose(input logic hand, input logic tracked,
                                        input int tx, input int ty, input int tz,
                                        input int px, input int py, input int pz);
        pose_t p;
        p.hand    = hand;
        p.tracked = tracked;
        p.tip_x   = POS_BITS'(tx);
        p.tip_y   = POS_BITS'(ty);
        p.tip_z   = POS_BITS'(tz);
        p.palm_x  = POS_BITS'(px);
        p.palm_y  = POS_BITS'(py);
        p.palm_z  = POS_BITS'(pz);
        return p;
    endfunction

    function automatic int rand_axis_offset(input int unsigned span);
        int mag;
        mag = $urandom_range(span);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // Most words put the fingertip at a distance on the scale of the current
    // reach, so the gate keeps toggling. A few are untracked, and some carry
    // fully random positions, which reach every bit and the saturation.
    function automatic pose_t rand_pose();
        pose_t p;
        int unsigned kind, base, span;
        kind = $urandom_range(99);
        p.hand    = 1'($urandom);
        p.tracked = (kind >= 8);
        p.palm_x  = POS_BITS'($urandom);
        p.palm_y  = POS_BITS'($urandom);
        p.palm_z  = POS_BITS'($urandom);
        p.tip_x   = POS_BITS'($urandom);
        p.tip_y   = POS_BITS'($urandom);
        p.tip_z   = POS_BITS'($urandom);
        if (kind >= 18) begin
            if ($urandom_range(3) != 0) begin
                p.palm_x = POS_BITS'($urandom_range(65535) - 32768);
                p.palm_y = POS_BITS'($urandom_range(65535) - 32768);
                p.palm_z = POS_BITS'($urandom_range(65535) - 32768);
            end
            base = ((cfg_initial_reach > cfg_reach_ceiling) ? cfg_initial_reach
                                                           : cfg_reach_ceiling) + 16;
            span = $urandom_range(base);
            p.tip_x = POS_BITS'(p.palm_x + rand_axis_offset(span));
            p.tip_y = POS_BITS'(p.palm_y + rand_axis_offset(span));
            p.tip_z = POS_BITS'(p.palm_z + rand_axis_offset(span));
        end
        return p;
    endfunction

    task automatic send_random_poses(input int count);
        repeat (count) send_pose(rand_pose());
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Untracked words right after reset: the gate reads off and nothing moves,
    // even with the positions at their extremes.
    task automatic test_untracked_after_reset();
        send_pose(make_pose(1'b0, 1'b0, POS_MAX_I, POS_MAX_I, POS_MAX_I,
                            POS_MIN_I, POS_MIN_I, POS_MIN_I));
        send_pose(make_pose(1'b1, 1'b0, POS_MIN_I, 0, POS_MAX_I, -1, -1, -1));
    endtask

    // Default registers: start above three quarters of the reach, stop only
    // below about 0.55 of it, with an untracked word while the gate is on.
    task automatic test_hysteresis_defaults();
        send_pose(make_pose(1'b0, 1'b1, 0, 0, 0, 0, 0, 0));
        send_pose(make_pose(1'b0, 1'b1, 500, 0, 0, 0, 0, 0));
        send_pose(make_pose(1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
        send_pose(make_pose(1'b0, 1'b1, 0, 300, 0, 0, 0, 0));
        send_pose(make_pose(1'b0, 1'b1, 0, 0, -200, 0, 0, 0));
        // Opposite corners: the distance saturates and the reach clamps.
        send_pose(make_pose(1'b1, 1'b1, POS_MAX_I, POS_MAX_I, POS_MAX_I,
                            POS_MIN_I, POS_MIN_I, POS_MIN_I));
        send_pose(make_pose(1'b1, 1'b1, POS_MIN_I, POS_MIN_I, POS_MIN_I,
                            POS_MAX_I, POS_MAX_I, POS_MAX_I));
    endtask

    // Ceiling below the floor: the clamp applies last, so the reach ends at
    // the ceiling, here zero.
    task automatic test_ceiling_below_floor();
        write_all_cfg(4095, 0, 192, 141);
        send_pose(make_pose(1'b0, 1'b1, 7, 7, 7, 7, 7, 7));
        send_pose(make_pose(1'b0, 1'b1, 1, 0, 0, 0, 0, 0));
        send_pose(make_pose(1'b0, 1'b1, 0, 0, 0, 0, 0, 0));
    endtask

    // Zero fractions: any nonzero distance starts the gate, and it never
    // stops.
    task automatic test_zero_fractions();
        write_all_cfg(0, 4095, 0, 0);
        send_pose(make_pose(1'b1, 1'b1, 0, 0, 0, 0, 0, 0));
        send_pose(make_pose(1'b0, 1'b1, 0, 0, 1, 0, 0, 0));
        send_pose(make_pose(1'b1, 1'b1, 0, -1, 0, 0, 0, 0));
    endtask

    // Registers at their extremes, in both directions.
    task automatic test_register_extremes();
        write_all_cfg(4095, 4095, 255, 255);
        send_pose(make_pose(1'b0, 1'b1, 0, 0, 0, 0, 0, 0));
        send_pose(make_pose(1'b1, 1'b1, 4095, 0, 0, 0, 0, 0));
        send_pose(make_pose(1'b0, 1'b1, POS_MAX_I, 0, 0, POS_MIN_I, 0, 0));
        write_all_cfg(0, 0, 255, 0);
        send_pose(make_pose(1'b1, 1'b1, 0, 0, 0, 0, 0, 0));
        send_pose(make_pose(1'b0, 1'b1, 3, -4, 0, 0, 0, 0));
    endtask

    task automatic test_random_defaults();
        write_all_cfg(RST_INITIAL_REACH, RST_REACH_CEILING,
                      RST_START_FRACTION, RST_STOP_FRACTION);
        send_random_poses(300);
    endtask

    // Several random register settings; the stop fraction usually sits below
    // the start fraction, but not always.
    task automatic test_random_configs();
        int unsigned reach_floor, reach_cap, start_frac, stop_frac;
        repeat (6) begin
            reach_floor = ($urandom_range(9) < 7) ? $urandom_range(800, 100)
                                                  : $urandom_range(4095);
            reach_cap   = ($urandom_range(9) < 7) ? $urandom_range(800, 100)
                                                  : $urandom_range(4095);
            start_frac  = ($urandom_range(9) < 7) ? $urandom_range(255, 96)
                                                  : $urandom_range(255);
            stop_frac   = ($urandom_range(9) < 7) ? $urandom_range(start_frac)
                                                  : $urandom_range(255);
            write_all_cfg(reach_floor, reach_cap, start_frac, stop_frac);
            send_random_poses(150);
        end
    endtask

    // Back-to-back words with the receiver always ready.
    task automatic test_without_idling();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random_poses(250);
        src_idle_pct  = 16;
        sink_idle_pct = 16;
    endtask

    // The receiver holds off for a long stretch while words keep coming: the
    // output register and the sequencer fill, and the input must stall.
    task automatic test_output_backpressure();
        hold_off_req = 300;
        send_random_poses(150);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_INITIAL_REACH;
        i_cfg_wdata     = '0;
        pose_if.valid   = 1'b0;
        pose_if.hand    = 1'b0;
        pose_if.tracked = 1'b0;
        pose_if.tip_x   = '0;
        pose_if.tip_y   = '0;
        pose_if.tip_z   = '0;
        pose_if.palm_x  = '0;
        pose_if.palm_y  = '0;
        pose_if.palm_z  = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_untracked_after_reset();
        test_hysteresis_defaults();
        test_ceiling_below_floor();
        test_zero_fractions();
        test_register_extremes();
        test_random_defaults();
        test_random_configs();
        test_without_idling();
        test_output_backpressure();

        settle_block();
        if (fail_count == 0 && gate_results_due.size() == 0) begin
            $display("** self_calibrating_pointing_gate: PASSED **");
        end else begin
            $display("** self_calibrating_pointing_gate: FAILED **");
        end
        $finish;
    end

endmodule
